// ===== rtl/cdf_pkg.sv =====
// package for the complex decimating fir: item types, fixed widths, coefficient rom
// no dependencies
`timescale 1ns / 1ps

package cdf_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int COEF_FRAC    = COEF_WIDTH - 1;
  localparam int ACC_WIDTH    = 40;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ROM_SIZE     = 64;
  localparam int ROM_AW       = 6;
  localparam int FACTOR_WIDTH = 5;
  localparam int COUNT_WIDTH  = 4;

  localparam logic [FACTOR_WIDTH-1:0] MAX_FACTOR   = 5'd16;
  localparam logic [FACTOR_WIDTH-1:0] FACTOR_RESET = 5'd8;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;

  typedef struct packed {
    sample_t in_i;
    sample_t in_q;
  } in_item_t;

  typedef struct packed {
    sample_t filtered_i;
    sample_t filtered_q;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctrl_t;

  localparam coef_t COEF_ROM [ROM_SIZE] = '{
    -18'sd29,   -18'sd60,   -18'sd104,  -18'sd159,
    -18'sd225,  -18'sd299,  -18'sd375,  -18'sd446,
    -18'sd505,  -18'sd541,  -18'sd543,  -18'sd501,
    -18'sd403,  -18'sd238,  18'sd0,     18'sd318,
    18'sd718,   18'sd1199,  18'sd1756,  18'sd2379,
    18'sd3055,  18'sd3766,  18'sd4492,  18'sd5210,
    18'sd5897,  18'sd6528,  18'sd7081,  18'sd7535,
    18'sd7873,  18'sd8081,  18'sd8151,  18'sd8081,
    18'sd7873,  18'sd7535,  18'sd7081,  18'sd6528,
    18'sd5897,  18'sd5210,  18'sd4492,  18'sd3766,
    18'sd3055,  18'sd2379,  18'sd1756,  18'sd1199,
    18'sd718,   18'sd318,   18'sd0,     -18'sd238,
    -18'sd403,  -18'sd501,  -18'sd543,  -18'sd541,
    -18'sd505,  -18'sd446,  -18'sd375,  -18'sd299,
    -18'sd225,  -18'sd159,  -18'sd104,  -18'sd60,
    -18'sd29,   18'sd0,     18'sd0,     18'sd0
  };

endpackage

// ===== rtl/cdf_history.sv =====
// circular i/q sample history: one synchronous memory, registered read
// entries not yet written since reset read as zero; uses cdf_pkg
`timescale 1ns / 1ps

module cdf_history #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  cdf_pkg::in_item_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output cdf_pkg::in_item_t rd_data
);
  import cdf_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(DEPTH);

  in_item_t      mem [DEPTH];
  in_item_t      rd_q;
  logic          rd_ok;
  logic [FW-1:0] fill;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // writes go in address order from zero, so a fill count marks written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en && fill != FULL) begin
        fill <= fill + 1'b1;
      end
      if (rd_en) begin
        rd_ok <= FW'(rd_addr) < fill;
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ===== rtl/cdf_mac.sv =====
// one channel multiply-accumulate with round and saturate to q1.15
// uses cdf_pkg
`timescale 1ns / 1ps

module cdf_mac (
  input  logic               clk,
  input  logic               rst,
  input  cdf_pkg::mac_ctrl_t ctrl,
  input  cdf_pkg::sample_t   sample,
  input  cdf_pkg::coef_t     coef,
  output cdf_pkg::sample_t   result,
  output logic               pend
);
  import cdf_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
    ACC_WIDTH'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
    ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_MIN = -SAT_MAX - ACC_WIDTH'(64'sd1);

  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH-1:0]  rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (ctrl.clear) begin
      pend <= 1'b0;
    end else begin
      pend <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      prod <= sample * coef;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (pend) begin
      acc <= acc + ACC_WIDTH'(prod);
    end
  end

  assign rounded = (acc + ROUND_HALF) >>> COEF_FRAC;

  always_comb begin
    if (rounded > SAT_MAX) begin
      result = SAMPLE_WIDTH'(SAT_MAX);
    end else if (rounded < SAT_MIN) begin
      result = SAMPLE_WIDTH'(SAT_MIN);
    end else begin
      result = rounded[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/complex_decimating_fir.sv =====
// complex decimating fir, top level: control, decimation count, output register
// uses cdf_pkg, cdf_history, cdf_mac
//
// in channel (in_valid/in_ready/in_item): one i/q sample per item. the sample is
// written to the history memory in the cycle it is accepted.
// out channel (out_valid/out_ready/out_item): one filtered i/q pair for every
// n-th input item, n being the decimation factor; none for the others.
// cfg channel (cfg_valid/cfg_ready/cfg_data): the decimation factor, always ready;
// zero acts as one, values above sixteen act as sixteen.
// an item that emits nothing leaves the control idle. an item that emits walks
// the TAPS history entries through the memory read port, one tap a cycle, into
// one multiplier per channel; its result shows on the out channel once it is
// loaded into the output register, and in_ready stays low until then, so the
// next item is not taken before that load.
// the output register holds a result while the receiver stalls; non-emitting
// items keep being accepted meanwhile, and a new result waits until it is free.
// reset clears the history (unwritten entries read as zero), the write position,
// the decimation count and the output valid, and sets the factor to 8.
`timescale 1ns / 1ps

module complex_decimating_fir #(
  parameter int TAPS          = 61,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cdf_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cdf_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cdf_pkg::FACTOR_WIDTH-1:0]   cfg_data
);
  import cdf_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [ROM_AW-1:0] LAST_TAP  = ROM_AW'(TAPS - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                  state;
  logic [FACTOR_WIDTH-1:0] factor;
  logic [FACTOR_WIDTH-1:0] eff_factor;
  logic [COUNT_WIDTH-1:0]  decim_count;
  logic [AW-1:0]           wr_pos;
  logic [AW-1:0]           wr_pos_next;
  logic [AW-1:0]           rd_addr;
  logic [ROM_AW-1:0]       tap;
  coef_t                   coef;
  logic                    issue_valid;
  logic                    accept;
  logic                    emit;
  logic                    load;
  logic                    pend_i;
  logic                    pend_q;
  in_item_t                hist_data;
  mac_ctrl_t               mac_ctrl;
  sample_t                 res_i;
  sample_t                 res_q;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (factor == '0) begin
      eff_factor = FACTOR_WIDTH'(1);
    end else if (factor > MAX_FACTOR) begin
      eff_factor = MAX_FACTOR;
    end else begin
      eff_factor = factor;
    end
  end

  assign emit        = (FACTOR_WIDTH'(decim_count) + 1'b1) >= eff_factor;
  assign wr_pos_next = (wr_pos == LAST_ADDR) ? '0 : wr_pos + 1'b1;
  assign load        = (state == S_DRAIN) && !issue_valid && !(pend_i || pend_q)
                       && (!out_valid || out_ready);

  assign mac_ctrl.clear = accept && emit;
  assign mac_ctrl.step  = issue_valid;

  cdf_history #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_history (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (wr_pos),
    .wr_data (in_item),
    .rd_en   (state == S_RUN),
    .rd_addr (rd_addr),
    .rd_data (hist_data)
  );

  cdf_mac u_mac_i (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (hist_data.in_i),
    .coef   (coef),
    .result (res_i),
    .pend   (pend_i)
  );

  cdf_mac u_mac_q (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (hist_data.in_q),
    .coef   (coef),
    .result (res_q),
    .pend   (pend_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      factor      <= FACTOR_RESET;
      decim_count <= '0;
      wr_pos      <= '0;
      issue_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        factor <= cfg_data;
      end
      issue_valid <= (state == S_RUN);
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            wr_pos <= wr_pos_next;
            if (emit) begin
              decim_count <= '0;
              rd_addr     <= wr_pos;
              tap         <= '0;
              state       <= S_RUN;
            end else begin
              decim_count <= decim_count + 1'b1;
            end
          end
        end
        S_RUN: begin
          rd_addr <= (rd_addr == '0) ? LAST_ADDR : rd_addr - 1'b1;
          tap     <= tap + 1'b1;
          coef    <= COEF_ROM[tap];
          if (tap == LAST_TAP) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load) begin
            out_item.filtered_i <= res_i;
            out_item.filtered_q <= res_q;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cdf_checker.sv =====
// port-level checks for complex_decimating_fir, attached by bind
// uses cdf_pkg
`timescale 1ns / 1ps

module cdf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cdf_pkg::out_item_t out_item
);
  import cdf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a result needs the whole tap walk, never the next cycle
  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after an item");

  // a new result is loaded only while the input side is held off
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result loaded while input was ready");

endmodule

bind complex_decimating_fir cdf_checker u_cdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== verif/complex_decimating_fir_tb.sv =====
// testbench for complex_decimating_fir: directed and random i/q sample streams against
// an in-bench fixed-point model of the 61-tap decimating filter and its history
// depends on cdf_pkg and complex_decimating_fir from rtl
`timescale 1ns / 1ps

module complex_decimating_fir_tb;
  import cdf_pkg::*;

  localparam int TAPS          = 61;
  localparam int DEPTH         = 64;
  localparam int SETTLE_CYCLES = TAPS + 20;
  localparam int IDLE_PCT      = 14;
  localparam int TARGET_ITEMS  = 550;

  int fir_coef [TAPS] = '{
      -29,   -60,  -104,  -159,  -225,  -299,  -375,  -446,
     -505,  -541,  -543,  -501,  -403,  -238,     0,   318,
      718,  1199,  1756,  2379,  3055,  3766,  4492,  5210,
     5897,  6528,  7081,  7535,  7873,  8081,  8151,  8081,
     7873,  7535,  7081,  6528,  5897,  5210,  4492,  3766,
     3055,  2379,  1756,  1199,   718,   318,     0,  -238,
     -403,  -501,  -543,  -541,  -505,  -446,  -375,  -299,
     -225,  -159,  -104,   -60,   -29
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_item_t                in_item = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_item;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [FACTOR_WIDTH-1:0] cfg_data = '0;

  sample_t                 i_history [DEPTH];
  sample_t                 q_history [DEPTH];
  logic [5:0]              wr_pos = '0;
  logic [COUNT_WIDTH-1:0]  decim_count = '0;
  logic [FACTOR_WIDTH-1:0] factor_setting = FACTOR_RESET;
  out_item_t               pending_outputs [$];

  int  errors = 0;
  int  mismatches = 0;
  int  samples_sent = 0;
  int  outputs_seen = 0;
  int  factor_writes = 0;
  int  saturated_seen = 0;
  bit  no_idle = 1'b0;

  complex_decimating_fir i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic sample_t round_sat(input longint acc);
    longint r;
    r = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return sample_t'(r);
  endfunction

  // history write, decimation count and convolution for one accepted sample
  function automatic void filter_sample(input in_item_t it);
    int        eff;
    int        pos;
    longint    acc_i;
    longint    acc_q;
    out_item_t res;
    i_history[wr_pos] = it.in_i;
    q_history[wr_pos] = it.in_q;
    eff = (factor_setting == 0) ? 1 :
          (factor_setting > MAX_FACTOR) ? int'(MAX_FACTOR) : int'(factor_setting);
    if (int'(decim_count) + 1 < eff) begin
      decim_count = decim_count + 1'b1;
      wr_pos = wr_pos + 1'b1;
      return;
    end
    decim_count = '0;
    acc_i = 0;
    acc_q = 0;
    pos = wr_pos;
    for (int k = 0; k < TAPS; k++) begin
      acc_i += longint'(fir_coef[k]) * longint'(i_history[pos]);
      acc_q += longint'(fir_coef[k]) * longint'(q_history[pos]);
      pos = (pos + DEPTH - 1) % DEPTH;
    end
    res.filtered_i = round_sat(acc_i);
    res.filtered_q = round_sat(acc_q);
    if (res.filtered_i == 16'sh7fff || res.filtered_i == -16'sh8000 ||
        res.filtered_q == 16'sh7fff || res.filtered_q == -16'sh8000)
      saturated_seen++;
    pending_outputs.push_back(res);
    wr_pos = wr_pos + 1'b1;
  endfunction

  // full-scale sample whose sign follows the tap that will weight it
  function automatic sample_t matched_value(input int age, input bit negate);
    bit     positive;
    int     amp;
    positive = ((age >= 15) && (age <= 45)) ^ negate;
    amp = $urandom_range(28000, 32767);
    return positive ? sample_t'(amp) : sample_t'(-amp - 1);
  endfunction

  task automatic send_sample(input sample_t si, input sample_t sq);
    in_item_t it;
    it.in_i = si;
    it.in_q = sq;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_sample(it);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_factor(input logic [FACTOR_WIDTH-1:0] f);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    factor_setting = f;
    factor_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      outputs_seen++;
      if (pending_outputs.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected output i=%0d q=%0d at %0t",
                   out_item.filtered_i, out_item.filtered_q, $realtime);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_item.filtered_i !== want.filtered_i ||
            out_item.filtered_q !== want.filtered_q) begin
          errors++;
          if (mismatches < 10) begin
            if (out_item.filtered_i !== want.filtered_i)
              $display("filtered_i mismatch: expected %0d got %0d at %0t",
                       want.filtered_i, out_item.filtered_i, $realtime);
            if (out_item.filtered_q !== want.filtered_q)
              $display("filtered_q mismatch: expected %0d got %0d at %0t",
                       want.filtered_q, out_item.filtered_q, $realtime);
          end
          mismatches++;
        end
      end
    end
  end

  // default factor of eight, history still zero
  task automatic test_startup();
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(-16'sh0001, 16'sh0001);
    send_sample(16'sh5555, sample_t'(16'haaaa));
    send_sample(sample_t'(16'haaaa), 16'sh5555);
    send_sample(16'sh0001, -16'sh0001);
    send_sample(16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_factor_zero();
    write_factor(5'd0);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, -16'sh8000);
  endtask

  task automatic test_factor_over_max();
    write_factor(5'd31);
    for (int k = 0; k < 16; k++)
      send_sample(sample_t'(k * 4000 - 30000), sample_t'(30000 - k * 4000));
  endtask

  task automatic test_factor_lowered();
    write_factor(5'd16);
    repeat (5) send_sample(sample_t'($urandom), sample_t'($urandom));
    write_factor(5'd2);
    send_sample(sample_t'($urandom), sample_t'($urandom));
  endtask

  // sign-matched full-scale bursts drive both channels into saturation
  task automatic test_overload_bursts();
    write_factor(5'd1);
    for (int b = 0; b < 2; b++) begin
      for (int j = 0; j < TAPS; j++)
        send_sample(matched_value(TAPS - 1 - j, b == 1), matched_value(TAPS - 1 - j, b == 0));
    end
  endtask

  task automatic test_random_stream();
    int                      phase;
    int                      len;
    int                      mode;
    int                      r;
    logic [FACTOR_WIDTH-1:0] f;
    sample_t                 dc_i;
    sample_t                 dc_q;
    bit                      neg_i;
    bit                      neg_q;
    phase = 0;
    while (samples_sent < TARGET_ITEMS) begin
      r = $urandom_range(99);
      if (r < 15) begin
        case ($urandom_range(3))
          0: f = 5'd0;
          1: f = 5'd1;
          2: f = 5'd16;
          default: f = 5'd31;
        endcase
      end else if (r < 70) begin
        f = FACTOR_WIDTH'($urandom_range(1, 4));
      end else begin
        f = FACTOR_WIDTH'($urandom_range(0, 31));
      end
      write_factor(f);
      no_idle = (phase == 3);
      len  = $urandom_range(20, 50);
      mode = $urandom_range(3);
      dc_i = sample_t'($urandom);
      dc_q = sample_t'($urandom);
      neg_i = $urandom_range(1);
      neg_q = $urandom_range(1);
      for (int n = 0; n < len; n++) begin
        if (phase == 5 && n == len / 2) wait_drained();
        case (mode)
          2: send_sample(dc_i, dc_q);
          3: send_sample(matched_value(TAPS - 1 - (n % TAPS), neg_i),
                         matched_value(TAPS - 1 - (n % TAPS), neg_q));
          default: send_sample(sample_t'($urandom), sample_t'($urandom));
        endcase
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      i_history[k] = '0;
      q_history[k] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_startup();
    test_factor_zero();
    test_factor_over_max();
    test_factor_lowered();
    test_overload_bursts();
    test_random_stream();

    wait_drained();
    if (pending_outputs.size() != 0) errors += pending_outputs.size();
    $display("sent %0d samples over %0d factor settings, checked %0d filtered pairs",
             samples_sent, factor_writes, outputs_seen);
    $display("%0d of the expected pairs hit a saturation limit, %0d failures",
             saturated_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
